// ===== design/momentum_predictor_stencil_core_assert.svh =====
// assertion macros for the momentum predictor stencil core
`ifndef MOMENTUM_PREDICTOR_STENCIL_CORE_ASSERT_SVH
`define MOMENTUM_PREDICTOR_STENCIL_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define MPS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define MPS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mps_pkg.sv =====
// shared types, constants and helper functions for the momentum predictor
`default_nettype none

package mps_pkg;

    localparam int GRID_CELLS  = 128;
    localparam int DATA_W      = 32;
    localparam int CFG_W       = 17;
    localparam int CFG_ADDR_W  = 2;
    localparam int MID_W       = 47;
    localparam int WIDE_W      = 64;
    localparam int FRAC_W      = 16;
    localparam int LAP_W       = DATA_W + 4;
    localparam int LO_W        = 24;
    localparam int HI_W        = MID_W - LO_W;
    localparam int PPL_W       = LO_W + 1 + CFG_W + 1;
    localparam int PPH_W       = HI_W + CFG_W + 1;
    localparam int LANE_STAGES = 7;
    localparam int NUM_FIELDS  = 10;
    localparam int IN_TDATA_W  = NUM_FIELDS * DATA_W;
    localparam int OUT_BITS    = 2 * DATA_W + 1;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CFG_ADDR_W-1:0] REG_TIME_STEP    = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_INV_REYNOLDS = CFG_ADDR_W'(1);

    localparam logic [CFG_W-1:0] TIME_STEP_RESET    = CFG_W'(100);
    localparam logic [CFG_W-1:0] INV_REYNOLDS_RESET = CFG_W'(655);

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [MID_W-1:0]  mid_t;
    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef logic signed [LAP_W-1:0]  lap_t;
    typedef logic [CFG_W-1:0]         cfg_t;

    localparam wide_t GRID_LIN = WIDE_W'(GRID_CELLS);
    localparam wide_t GRID_SQ  = WIDE_W'(GRID_CELLS * GRID_CELLS);
    localparam wide_t MID_MAX  = {{(WIDE_W - MID_W + 1){1'b0}}, {(MID_W - 1){1'b1}}};
    localparam wide_t MID_MIN  = ~MID_MAX;
    localparam wide_t DATA_MAX = {{(WIDE_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
    localparam wide_t DATA_MIN = ~DATA_MAX;

    typedef struct packed {
        data_t c;
        data_t e;
        data_t w;
        data_t n;
        data_t s;
    } hood_t;

    typedef struct packed {
        data_t fe;
        data_t fw;
        data_t fn;
        data_t fs;
    } face_t;

    typedef struct packed {
        logic [LANE_STAGES-1:0] load;
    } pipe_ctl_t;

    typedef struct packed {
        data_t value;
        logic  ovf;
    } lane_out_t;

    // floor((a + b) / 2) on the exact sum
    function automatic data_t half_sum(input data_t a, input data_t b);
        logic signed [DATA_W:0] sum;
        sum = (DATA_W + 1)'(a) + (DATA_W + 1)'(b);
        return sum[DATA_W:1];
    endfunction

    function automatic mid_t clamp_mid(input wide_t x);
        if (x > MID_MAX) begin
            return MID_MAX[MID_W-1:0];
        end else if (x < MID_MIN) begin
            return MID_MIN[MID_W-1:0];
        end
        return x[MID_W-1:0];
    endfunction

    function automatic logic clamp_hit(input wide_t x);
        return (x > MID_MAX) || (x < MID_MIN);
    endfunction

endpackage

`default_nettype wire

// ===== design/momentum_predictor_stencil_core.sv =====
// top level of the explicit momentum predictor stencil core
//
//  channel   | direction | transfer on          | payload
//  s_axis    | in        | s_tvalid & s_tready  | ten Q16.16 velocities of one cell
//  m_axis    | out       | m_tvalid & m_tready  | new_u, new_v, overflow
//  cfg       | in        | cfg_wen              | time_step, inv_reynolds
//
// one cell per clock sustained while m_tready is high; an input transfer reaches m_tvalid through
// the input register, seven lane stages and the output register
// the u and v lanes run side by side; the multiplier stages set the depth
// reset clears the valid bits and reloads the configuration; data registers are not reset
// back pressure holds only occupied stages, bubbles are squeezed out
`default_nettype none

`include "momentum_predictor_stencil_core_assert.svh"

module momentum_predictor_stencil_core import mps_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // u_center, u_east, u_west, u_north, u_south, v_center, v_east, v_west,
    // v_north, v_south (32 bits each)
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // new_u (32), new_v (32), overflow (1), zero padding
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    input  wire logic                   cfg_wen,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [CFG_W-1:0]       cfg_wdata
);

    cfg_t time_step_reg, time_step_next;
    cfg_t inv_reynolds_reg, inv_reynolds_next;

    logic [LANE_STAGES:0]   vld_reg, vld_next;
    logic [LANE_STAGES+1:0] go;
    logic                   out_ready;

    hood_t     u_hood_reg, v_hood_reg;
    face_t     face;
    pipe_ctl_t ctl;
    lane_out_t u_res, v_res;

    always_comb begin
        time_step_next    = time_step_reg;
        inv_reynolds_next = inv_reynolds_reg;
        if (cfg_wen) begin
            unique case (cfg_addr)
                REG_TIME_STEP:    time_step_next    = cfg_wdata;
                REG_INV_REYNOLDS: inv_reynolds_next = cfg_wdata;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg    <= TIME_STEP_RESET;
            inv_reynolds_reg <= INV_REYNOLDS_RESET;
        end else begin
            time_step_reg    <= time_step_next;
            inv_reynolds_reg <= inv_reynolds_next;
        end
    end

    // a stage may load when it is empty or its content moves on
    always_comb begin
        go[LANE_STAGES+1] = out_ready;
        for (int k = LANE_STAGES; k >= 0; k--) begin
            go[k] = !vld_reg[k] || go[k+1];
        end
        vld_next[0] = go[0] ? s_tvalid : vld_reg[0];
        for (int k = 1; k <= LANE_STAGES; k++) begin
            vld_next[k] = go[k] ? vld_reg[k-1] : vld_reg[k];
        end
        ctl.load = go[LANE_STAGES:1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (go[0]) begin
            u_hood_reg.c <= s_tdata[0*DATA_W +: DATA_W];
            u_hood_reg.e <= s_tdata[1*DATA_W +: DATA_W];
            u_hood_reg.w <= s_tdata[2*DATA_W +: DATA_W];
            u_hood_reg.n <= s_tdata[3*DATA_W +: DATA_W];
            u_hood_reg.s <= s_tdata[4*DATA_W +: DATA_W];
            v_hood_reg.c <= s_tdata[5*DATA_W +: DATA_W];
            v_hood_reg.e <= s_tdata[6*DATA_W +: DATA_W];
            v_hood_reg.w <= s_tdata[7*DATA_W +: DATA_W];
            v_hood_reg.n <= s_tdata[8*DATA_W +: DATA_W];
            v_hood_reg.s <= s_tdata[9*DATA_W +: DATA_W];
        end
    end

    // face velocities shared by both lanes
    always_comb begin
        face.fe = half_sum(u_hood_reg.c, u_hood_reg.e);
        face.fw = half_sum(u_hood_reg.w, u_hood_reg.c);
        face.fn = half_sum(v_hood_reg.c, v_hood_reg.n);
        face.fs = half_sum(v_hood_reg.s, v_hood_reg.c);
    end

    mps_lane u_lane (
        .aclk         (aclk),
        .ctl          (ctl),
        .hood         (u_hood_reg),
        .face         (face),
        .time_step    (time_step_reg),
        .inv_reynolds (inv_reynolds_reg),
        .result       (u_res)
    );

    mps_lane v_lane (
        .aclk         (aclk),
        .ctl          (ctl),
        .hood         (v_hood_reg),
        .face         (face),
        .time_step    (time_step_reg),
        .inv_reynolds (inv_reynolds_reg),
        .result       (v_res)
    );

    mps_merge merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vld_reg[LANE_STAGES]),
        .u_res     (u_res),
        .v_res     (v_res),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .out_ready (out_ready)
    );

    assign s_tready = go[0];

    `MPS_ASSERT_NEXT(a_time_step_write, aclk, aresetn, cfg_wen && (cfg_addr == REG_TIME_STEP), time_step_reg == $past(cfg_wdata), "time_step register missed a write")

    `MPS_ASSERT_NOW(a_full_stall_blocks_input, aclk, aresetn, (&vld_reg) && m_tvalid && !m_tready, !s_tready, "input accepted while pipeline full and stalled")

    `MPS_ASSERT_NEXT(a_last_stage_holds, aclk, aresetn, vld_reg[LANE_STAGES] && !out_ready, vld_reg[LANE_STAGES], "last lane stage dropped a stalled item")

endmodule

`default_nettype wire

// ===== design/mps_lane.sv =====
// one velocity component lane: fluxes, laplacian, viscosity and time advance
`default_nettype none

module mps_lane import mps_pkg::*; (
    input  wire logic      aclk,
    input  wire pipe_ctl_t ctl,
    input  wire hood_t     hood,
    input  wire face_t     face,
    input  wire cfg_t      time_step,
    input  wire cfg_t      inv_reynolds,
    output lane_out_t      result
);

    // stage 1: half sums and laplacian sum
    data_t h_e_reg, h_w_reg, h_n_reg, h_s_reg;
    data_t f_e_reg, f_w_reg, f_n_reg, f_s_reg;
    lap_t  lap_sum_reg, lap_sum_next;
    data_t c1_reg;

    // stage 2: flux products and scaled laplacian
    wide_t p_e_reg, p_w_reg, p_n_reg, p_s_reg;
    wide_t lap_w;
    mid_t  lap_reg;
    logic  ov2_reg;
    data_t c2_reg;

    // stage 3: convective differences and viscous partial products
    wide_t d_x_w, d_y_w, dx_w, dy_w;
    mid_t  dx_reg, dy_reg;
    logic signed [PPL_W-1:0] vpl_reg, vpl_next;
    logic signed [PPH_W-1:0] vph_reg, vph_next;
    logic  ov3_reg;
    data_t c3_reg;

    // stage 4: viscous term and summed convection
    wide_t visc_prod, visc_w;
    mid_t  visc_reg;
    logic signed [MID_W:0] dxy_reg, dxy_next;
    logic  ov4_reg;
    data_t c4_reg;

    // stage 5: rate of change
    wide_t rate_w;
    mid_t  rate_reg;
    logic  ov5_reg;
    data_t c5_reg;

    // stage 6: time step partial products
    logic signed [PPL_W-1:0] tpl_reg, tpl_next;
    logic signed [PPH_W-1:0] tph_reg, tph_next;
    logic  ov6_reg;
    data_t c6_reg;

    // stage 7: advance and saturate
    wide_t step_prod, new_w;
    lane_out_t result_reg, result_next;

    always_comb begin
        lap_sum_next = LAP_W'(hood.w) + LAP_W'(hood.e) + LAP_W'(hood.s) + LAP_W'(hood.n)
                     - (LAP_W'(hood.c) <<< 2);
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            h_e_reg     <= half_sum(hood.c, hood.e);
            h_w_reg     <= half_sum(hood.w, hood.c);
            h_n_reg     <= half_sum(hood.c, hood.n);
            h_s_reg     <= half_sum(hood.s, hood.c);
            f_e_reg     <= face.fe;
            f_w_reg     <= face.fw;
            f_n_reg     <= face.fn;
            f_s_reg     <= face.fs;
            lap_sum_reg <= lap_sum_next;
            c1_reg      <= hood.c;
        end
    end

    always_comb begin
        lap_w = WIDE_W'(lap_sum_reg) * GRID_SQ;
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[1]) begin
            p_e_reg <= WIDE_W'(f_e_reg) * WIDE_W'(h_e_reg);
            p_w_reg <= WIDE_W'(f_w_reg) * WIDE_W'(h_w_reg);
            p_n_reg <= WIDE_W'(f_n_reg) * WIDE_W'(h_n_reg);
            p_s_reg <= WIDE_W'(f_s_reg) * WIDE_W'(h_s_reg);
            lap_reg <= clamp_mid(lap_w);
            ov2_reg <= clamp_hit(lap_w);
            c2_reg  <= c1_reg;
        end
    end

    always_comb begin
        d_x_w    = (p_e_reg >>> FRAC_W) - (p_w_reg >>> FRAC_W);
        d_y_w    = (p_n_reg >>> FRAC_W) - (p_s_reg >>> FRAC_W);
        dx_w     = d_x_w * GRID_LIN;
        dy_w     = d_y_w * GRID_LIN;
        vpl_next = PPL_W'($signed({1'b0, lap_reg[LO_W-1:0]}))
                 * PPL_W'($signed({1'b0, inv_reynolds}));
        vph_next = PPH_W'($signed(lap_reg[MID_W-1:LO_W]))
                 * PPH_W'($signed({1'b0, inv_reynolds}));
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[2]) begin
            dx_reg  <= clamp_mid(dx_w);
            dy_reg  <= clamp_mid(dy_w);
            vpl_reg <= vpl_next;
            vph_reg <= vph_next;
            ov3_reg <= ov2_reg | clamp_hit(dx_w) | clamp_hit(dy_w);
            c3_reg  <= c2_reg;
        end
    end

    always_comb begin
        visc_prod = (WIDE_W'(vph_reg) <<< LO_W) + WIDE_W'(vpl_reg);
        visc_w    = visc_prod >>> FRAC_W;
        dxy_next  = (MID_W + 1)'(dx_reg) + (MID_W + 1)'(dy_reg);
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[3]) begin
            visc_reg <= clamp_mid(visc_w);
            dxy_reg  <= dxy_next;
            ov4_reg  <= ov3_reg | clamp_hit(visc_w);
            c4_reg   <= c3_reg;
        end
    end

    always_comb begin
        rate_w = WIDE_W'(visc_reg) - WIDE_W'(dxy_reg);
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[4]) begin
            rate_reg <= clamp_mid(rate_w);
            ov5_reg  <= ov4_reg | clamp_hit(rate_w);
            c5_reg   <= c4_reg;
        end
    end

    always_comb begin
        tpl_next = PPL_W'($signed({1'b0, rate_reg[LO_W-1:0]}))
                 * PPL_W'($signed({1'b0, time_step}));
        tph_next = PPH_W'($signed(rate_reg[MID_W-1:LO_W]))
                 * PPH_W'($signed({1'b0, time_step}));
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[5]) begin
            tpl_reg <= tpl_next;
            tph_reg <= tph_next;
            ov6_reg <= ov5_reg;
            c6_reg  <= c5_reg;
        end
    end

    always_comb begin
        step_prod = (WIDE_W'(tph_reg) <<< LO_W) + WIDE_W'(tpl_reg);
        new_w     = WIDE_W'(c6_reg) + (step_prod >>> FRAC_W);
        priority if (new_w > DATA_MAX) begin
            result_next.value = DATA_MAX[DATA_W-1:0];
            result_next.ovf   = 1'b1;
        end else if (new_w < DATA_MIN) begin
            result_next.value = DATA_MIN[DATA_W-1:0];
            result_next.ovf   = 1'b1;
        end else begin
            result_next.value = new_w[DATA_W-1:0];
            result_next.ovf   = ov6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[6]) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ===== design/mps_merge.sv =====
// merges the two lane results into the output register
`default_nettype none

module mps_merge import mps_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    input  wire lane_out_t              u_res,
    input  wire lane_out_t              v_res,
    input  wire logic                   m_tready,
    output logic                        m_tvalid,
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    output logic                        out_ready
);

    logic                   valid_reg, valid_next;
    logic [OUT_TDATA_W-1:0] data_reg, data_next;

    assign out_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = out_ready ? in_valid : valid_reg;
        data_next  = OUT_TDATA_W'({u_res.ovf | v_res.ovf, v_res.value, u_res.value});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready) begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

`default_nettype wire
